// ----- rtl/core/hsv2rgb_pkg.sv -----
// Shared constants and types for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned FracW  = 17;   // Q1.16 saturation / brightness
  localparam int unsigned WeightW = 6;   // hexcone weight f, 0..60
  localparam int unsigned ByteW  = 8;

  localparam logic [FracW-1:0] Q16One = 17'd65536;

  localparam logic [HueW-1:0] HueSector    = 9'd60;
  localparam logic [HueW-1:0] HueDouble    = 9'd120;
  localparam logic [HueW-1:0] HueHalf      = 9'd180;
  localparam logic [HueW-1:0] HueTwoThirds = 9'd240;
  localparam logic [HueW-1:0] HueFiveSixth = 9'd300;
  localparam logic [HueW-1:0] HueFull      = 9'd360;

  // floor(t / 60) == (t * Recip60) >> Recip60Shift for t <= 15300
  localparam logic [14:0] Recip60      = 15'd17477;
  localparam int unsigned Recip60Shift = 20;
  localparam logic [13:0] ScaledMax    = 14'd15300;  // 255 * 60

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYAN = 3'd2,
    SEC_CYAN_BLU = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e              sector;
    logic [WeightW-1:0]   weight;  // 60 - |(H mod 120) - 60|
  } hue_dec_t;

endpackage : hsv2rgb_pkg

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_convert.sv -----
// Top level: six-stage pipelined HSV to RGB pixel converter.
// An accepted input transaction moves through the stage registers in order up to m_axis_tvalid.
// Throughput: one pixel per cycle; the pipeline advances as a whole whenever
//   the output register is empty or is being taken, so a stall holds every stage.
// Reset: rst_ni (async, active low) clears all stage valid bits; data regs
//   carry no reset. No state is kept between pixels.
`default_nettype none

module hsv_to_rgb_convert
  import hsv2rgb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [8:0] hue, [25:9] saturation, [42:26] brightness, [47:43] zero pad
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0]      m_axis_tdata
);

  localparam int unsigned Stages = 6;

  // Stage valid bits; the last one is the output register valid.
  logic [Stages-1:0] vld_q, vld_d;
  logic              en;

  assign en            = ~vld_q[Stages-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Stages-1];

  assign vld_d = {vld_q[Stages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: clamp S and V to one, decode hue.
  // ---------------------------------------------------------------------
  logic [HueW-1:0]  hue_in;
  logic [FracW-1:0] sat_in, bri_in;
  hue_dec_t         hue_dec;

  assign hue_in = s_axis_tdata[8:0];
  assign sat_in = s_axis_tdata[25:9];
  assign bri_in = s_axis_tdata[42:26];

  hsv2rgb_sector u_sector (
    .hue_i (hue_in),
    .dec_o (hue_dec)
  );

  logic [FracW-1:0] s1_q, s1_d, v1_q, v1_d;
  hue_dec_t         dec1_q;

  assign s1_d = (sat_in > Q16One) ? Q16One : sat_in;
  assign v1_d = (bri_in > Q16One) ? Q16One : bri_in;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      v1_q   <= v1_d;
      dec1_q <= hue_dec;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: chroma C = S*V (Q2.32), C channel byte = floor(255*V/2^16).
  // ---------------------------------------------------------------------
  logic [2*FracW-1:0] sv_full;
  logic [24:0]        v255;
  logic [32:0]        sv2_q, sv2_d;
  logic [FracW-1:0]   v2_q;
  logic [ByteW-1:0]   bc2_q, bc2_d;
  hue_dec_t           dec2_q;

  assign sv_full = s1_q * v1_q;
  assign sv2_d   = sv_full[32:0];            // at most 2^32
  assign v255    = {v1_q, 8'b0} - {8'b0, v1_q};
  assign bc2_d   = v255[23:16];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sv2_q  <= sv2_d;
      v2_q   <= v1_q;
      bc2_q  <= bc2_d;
      dec2_q <= dec1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: offset m = V - C, secondary product C*f.
  // ---------------------------------------------------------------------
  logic [32:0]      m3_q, m3_d;
  logic [38:0]      svf3_q, svf3_d;
  logic [ByteW-1:0] bc3_q;
  sector_e          sec3_q;

  assign m3_d   = {v2_q, 16'b0} - sv2_q;
  assign svf3_d = sv2_q * dec2_q.weight;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_q   <= m3_d;
      svf3_q <= svf3_d;
      bc3_q  <= bc2_q;
      sec3_q <= dec2_q.sector;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: X numerator 60*m + C*f (over 60*2^32), zero channel byte.
  // ---------------------------------------------------------------------
  logic [40:0]      m255;
  logic [38:0]      n_sum;
  logic [37:0]      n4_q;
  logic [ByteW-1:0] bz4_q, bz4_d, bc4_q;
  sector_e          sec4_q;

  assign m255  = {m3_q, 8'b0} - {8'b0, m3_q};
  assign bz4_d = m255[39:32];
  assign n_sum = {m3_q, 6'b0} - {4'b0, m3_q, 2'b0} + svf3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q   <= n_sum[37:0];   // at most 60 * 2^32
      bz4_q  <= bz4_d;
      bc4_q  <= bc3_q;
      sec4_q <= sec3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: t = floor(255*N / 2^32), at most 255*60.
  // ---------------------------------------------------------------------
  logic [45:0]      n255;
  logic [13:0]      t5_q;
  logic [ByteW-1:0] bz5_q, bc5_q;
  sector_e          sec5_q;

  assign n255 = {n4_q, 8'b0} - {8'b0, n4_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_q   <= n255[45:32];
      bz5_q  <= bz4_q;
      bc5_q  <= bc4_q;
      sec5_q <= sec4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: X byte = floor(t/60) by reciprocal, channel routing, output.
  // ---------------------------------------------------------------------
  logic [28:0]      t_recip;
  logic [ByteW-1:0] bx6;
  logic [ByteW-1:0] red_d, green_d, blue_d;
  logic [ByteW-1:0] red_q, green_q, blue_q;

  assign t_recip = t5_q * Recip60;
  assign bx6     = t_recip[Recip60Shift+ByteW-1:Recip60Shift];

  always_comb begin
    case (sec5_q)
      SEC_RED_YEL:  begin red_d = bc5_q; green_d = bx6;   blue_d = bz5_q; end
      SEC_YEL_GRN:  begin red_d = bx6;   green_d = bc5_q; blue_d = bz5_q; end
      SEC_GRN_CYAN: begin red_d = bz5_q; green_d = bc5_q; blue_d = bx6;   end
      SEC_CYAN_BLU: begin red_d = bz5_q; green_d = bx6;   blue_d = bc5_q; end
      SEC_BLU_MAG:  begin red_d = bx6;   green_d = bz5_q; blue_d = bc5_q; end
      default:      begin red_d = bc5_q; green_d = bz5_q; blue_d = bx6;   end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign m_axis_tdata = {blue_q, green_q, red_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_accept_fills_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction did not enter stage 1");

  a_weight_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> dec1_q.weight <= HueSector[WeightW-1:0])
    else $error("hexcone weight above 60");

  a_chroma_le_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> sv2_q <= {v2_q, 16'b0})
    else $error("chroma exceeds value, offset would wrap");

  a_scaled_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> t5_q <= ScaledMax)
    else $error("scaled secondary numerator out of range");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && !en |=> $stable(t5_q) && $stable(bc5_q) && $stable(bz5_q))
    else $error("stage 5 data changed during stall");

endmodule : hsv_to_rgb_convert

`default_nettype wire

// ----- rtl/core/hsv2rgb_sector.sv -----
// Hue decode: wrap, 60-degree sector and secondary weight.
`default_nettype none

module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  wire logic [HueW-1:0] hue_i,
  output hue_dec_t             dec_o
);

  logic [HueW-1:0] hue_wrap;
  logic [HueW-1:0] hue_mod;   // hue mod 120
  logic [HueW-1:0] weight;

  always_comb begin
    hue_wrap = (hue_i >= HueFull) ? hue_i - HueFull : hue_i;

    if (hue_wrap >= HueTwoThirds) begin
      hue_mod = hue_wrap - HueTwoThirds;
    end else if (hue_wrap >= HueDouble) begin
      hue_mod = hue_wrap - HueDouble;
    end else begin
      hue_mod = hue_wrap;
    end

    weight = (hue_mod <= HueSector) ? hue_mod : HueDouble - hue_mod;

    if (hue_wrap >= HueFiveSixth) begin
      dec_o.sector = SEC_MAG_RED;
    end else if (hue_wrap >= HueTwoThirds) begin
      dec_o.sector = SEC_BLU_MAG;
    end else if (hue_wrap >= HueHalf) begin
      dec_o.sector = SEC_CYAN_BLU;
    end else if (hue_wrap >= HueDouble) begin
      dec_o.sector = SEC_GRN_CYAN;
    end else if (hue_wrap >= HueSector) begin
      dec_o.sector = SEC_YEL_GRN;
    end else begin
      dec_o.sector = SEC_RED_YEL;
    end
    dec_o.weight = weight[WeightW-1:0];
  end

endmodule : hsv2rgb_sector

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the hsv_to_rgb_convert streaming pixel converter.
module tb
  import hsv2rgb_pkg::*;
;

  localparam int unsigned DataPad  = 48 - (HueW + 2 * FracW);
  localparam int unsigned ByteMax  = 255;
  localparam int unsigned HoldLen  = 60;   // long receiver hold-off, in cycles
  localparam int unsigned DrainLen = 20;   // latency margin after the last pixel
  localparam int unsigned PhaseLen = 340;  // random pixels per idling phase

  // last field in the lowest bits
  typedef struct packed {
    logic [FracW-1:0] brightness;
    logic [FracW-1:0] saturation;
    logic [HueW-1:0]  hue;
  } hsv_t;

  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } rgb_t;

  typedef struct {
    logic known;   // rgb typed in by hand, otherwise predicted
    rgb_t rgb;
    hsv_t px;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  rgb_t     rgb_expected_q[$];
  dir_row_t dir_rows[$];
  int       mismatch_cnt   = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       hold_req_cnt   = 0;

  hsv_to_rgb_convert u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("** hsv_to_rgb_convert: FAILED **");
    $finish;
  end

  // floor(255 * num / (60 * 2^32)), clamped to a byte
  function automatic logic [ByteW-1:0] level_to_byte(input logic [63:0] num);
    logic [63:0] q;
    q = (num * 64'(ByteMax)) / (64'(HueSector) << 32);
    return (q > 64'(ByteMax)) ? ByteW'(ByteMax) : q[ByteW-1:0];
  endfunction

  function automatic rgb_t hsv_to_rgb_expect(input hsv_t px);
    logic [HueW-1:0]  hue;
    logic [HueW-1:0]  rem;
    logic [FracW-1:0] sat;
    logic [FracW-1:0] bri;
    logic [63:0]      chroma, bri32, offs, weight;
    logic [ByteW-1:0] b_c, b_x, b_z;
    sector_e          sec;
    rgb_t             rgb;
    hue = px.hue;
    if (hue >= HueFull) hue = hue - HueFull;  // one wrap covers all 9-bit hues
    sat = (px.saturation > Q16One) ? Q16One : px.saturation;
    bri = (px.brightness > Q16One) ? Q16One : px.brightness;
    chroma = 64'(sat) * 64'(bri);             // Q2.32
    bri32  = 64'(bri) << 16;
    offs   = bri32 - chroma;
    rem    = hue % HueDouble;
    weight = (rem <= HueSector) ? 64'(rem) : 64'(HueDouble - rem);
    b_c = level_to_byte(64'(HueSector) * bri32);
    b_x = level_to_byte(64'(HueSector) * offs + chroma * weight);
    b_z = level_to_byte(64'(HueSector) * offs);
    sec = sector_e'(3'(hue / HueSector));
    case (sec)
      SEC_RED_YEL:  rgb = '{blue: b_z, green: b_x, red: b_c};
      SEC_YEL_GRN:  rgb = '{blue: b_z, green: b_c, red: b_x};
      SEC_GRN_CYAN: rgb = '{blue: b_x, green: b_c, red: b_z};
      SEC_CYAN_BLU: rgb = '{blue: b_c, green: b_x, red: b_z};
      SEC_BLU_MAG:  rgb = '{blue: b_c, green: b_z, red: b_x};
      default:      rgb = '{blue: b_x, green: b_z, red: b_c};
    endcase
    return rgb;
  endfunction

  function automatic dir_row_t mk_row(input logic known, input int r, input int g,
                                      input int b, input int h, input int s,
                                      input int v);
    dir_row_t row;
    row.known         = known;
    row.rgb.red       = ByteW'(r);
    row.rgb.green     = ByteW'(g);
    row.rgb.blue      = ByteW'(b);
    row.px.hue        = HueW'(h);
    row.px.saturation = FracW'(s);
    row.px.brightness = FracW'(v);
    return row;
  endfunction

  function automatic hsv_t rand_pixel();
    hsv_t px;
    int   pick;
    px.hue = ($urandom_range(0, 9) == 0) ? HueW'($urandom_range(0, 511))
                                         : HueW'($urandom_range(0, 359));
    pick = $urandom_range(0, 9);
    if (pick < 7)       px.saturation = FracW'($urandom_range(0, 65536));
    else if (pick == 7) px.saturation = ($urandom_range(0, 1) != 0) ? Q16One : '0;
    else                px.saturation = FracW'($urandom_range(0, 131071));
    pick = $urandom_range(0, 9);
    if (pick < 7)       px.brightness = FracW'($urandom_range(0, 65536));
    else if (pick == 7) px.brightness = ($urandom_range(0, 1) != 0) ? Q16One : '0;
    else                px.brightness = FracW'($urandom_range(0, 131071));
    return px;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic offer_pixel(input hsv_t px, input rgb_t rgb_exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {DataPad'(0), px};
    do @(posedge clk_i); while (!s_axis_tready);
    rgb_expected_q.push_back(rgb_exp);
  endtask

  task automatic wait_drained();
    while (rgb_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Output side: check every result transaction, then pick the next tready.
  initial begin
    int hold_seen;
    int hold_left;
    rgb_t got;
    rgb_t want;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = rgb_t'(m_axis_tdata);
        if (rgb_expected_q.size() == 0) begin
          $error("unexpected result transaction rgb=%h", got);
          mismatch_cnt++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatch_cnt++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatch_cnt++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatch_cnt++;
          end
        end
      end
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HoldLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Input side: directed table, then random pixels over the idling phases.
  initial begin
    hsv_t px;
    int   phase;
    dir_rows = '{
      mk_row(1'b1,   0,   0,   0,   0, 65536,      0),  // black
      mk_row(1'b1,   0,   0,   0,   0,     0,      0),
      mk_row(1'b1, 255, 255, 255, 200,     0,  65536),  // white, no chroma
      mk_row(1'b1, 255,   0,   0,   0, 65536,  65536),  // sector starts
      mk_row(1'b1, 255, 255,   0,  60, 65536,  65536),
      mk_row(1'b1,   0, 255,   0, 120, 65536,  65536),
      mk_row(1'b1,   0, 255, 255, 180, 65536,  65536),
      mk_row(1'b1,   0,   0, 255, 240, 65536,  65536),
      mk_row(1'b1, 255,   0, 255, 300, 65536,  65536),
      mk_row(1'b1, 255,   0,   0, 360, 65536,  65536),  // hue wraps
      mk_row(1'b1,   0, 255,   0, 480, 65536,  65536),
      mk_row(1'b0,   0,   0,   0, 511, 65536,  65536),
      mk_row(1'b0,   0,   0,   0, 359, 65536,  65536),
      mk_row(1'b1, 255,   0,   0,   0, 131071, 65536), // saturation clamps
      mk_row(1'b1, 255, 255, 255,   0,     0, 131071),  // brightness clamps
      mk_row(1'b1,   0,   0, 255, 240, 131071, 131071),
      mk_row(1'b0,   0,   0,   0,  59, 65536,  65536),  // either side of a boundary
      mk_row(1'b0,   0,   0,   0,  61, 65536,  65536),
      mk_row(1'b0,   0,   0,   0, 119, 65536,  65536),
      mk_row(1'b0,   0,   0,   0,   1, 65536,  65536),
      mk_row(1'b0,   0,   0,   0,  30, 32768,  32768),
      mk_row(1'b0,   0,   0,   0, 299, 65535,  65535),
      mk_row(1'b0,   0,   0,   0,   0,     0,      1)   // tiny brightness
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer_pixel(dir_rows[i].px,
                  dir_rows[i].known ? dir_rows[i].rgb : hsv_to_rgb_expect(dir_rows[i].px));
    end

    // phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 61 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 61 : (phase == 3) ? 19 : 0;
      // long receiver hold-off while the sender keeps pushing, fills the pipe
      if (phase == 0 || phase == 2) hold_req_cnt++;
      for (int n = 0; n < PhaseLen; n++) begin
        px = rand_pixel();
        offer_pixel(px, hsv_to_rgb_expect(px));
      end
      // sender pauses until every pending pixel has come out
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (DrainLen) @(posedge clk_i);
    if (mismatch_cnt == 0 && rgb_expected_q.size() == 0) begin
      $display("** hsv_to_rgb_convert: PASSED **");
    end else begin
      $display("** hsv_to_rgb_convert: FAILED **");
    end
    $finish;
  end

endmodule
